>>> hdl/sala_pkg.sv
// Shared constants and types of the set-associative line array.
`default_nettype none
package sala_pkg;

   localparam int SETS          = 1024;
   localparam int SET_W         = $clog2(SETS);
   localparam int WAYS_DEF      = 32;
   localparam int LINE_BITS_DEF = 40;

   localparam int OP_W    = 2;
   localparam int LINE_W  = 40;
   localparam int SIDX_W  = 10;
   localparam int WAY_W   = 5;
   localparam int CFG_W   = 6;

   localparam logic [CFG_W-1:0] WAYS_USED_RESET = CFG_W'(32);

   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP = 2'd0,
      OP_LIST   = 2'd1,
      OP_INSERT = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL,
      ST_OUT,
      ST_LIST
   } state_type;

endpackage
`default_nettype wire

>>> hdl/sala_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module sala_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

>>> hdl/set_associative_line_array_top.sv
// Top level: set-associative line array, one RAM row per set (valid bits and line ids).
// Lookup and insert: compare in EVAL, result loaded in OUT; a new item can be accepted in OUT.
// List candidates: n = effective ways; n consecutive result strobes.
// The RAM row read and the way compare set the pace (read, compare and insert write, encode).
// Reset: a clearing pass writes every set row with busy high; ways_used resets to 32.
// The receiver cannot stall; each result is flagged by rsp_strobe for exactly one cycle.
`default_nettype none
module set_associative_line_array_top #(
   parameter int WAYS      = sala_pkg::WAYS_DEF,
   parameter int LINE_BITS = sala_pkg::LINE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [sala_pkg::OP_W-1:0]     req_op,
   input  wire logic [sala_pkg::LINE_W-1:0]   req_line_id,
   input  wire logic [sala_pkg::SIDX_W-1:0]   req_set_index,
   input  wire logic [sala_pkg::WAY_W-1:0]    req_way,
   input  wire logic                          csr_write_en,
   input  wire logic [sala_pkg::CFG_W-1:0]    csr_write_data,
   output logic                               rsp_strobe,
   output logic                               rsp_hit,
   output logic      [sala_pkg::WAY_W-1:0]    rsp_hit_way,
   output logic                               rsp_free_found,
   output logic      [sala_pkg::WAY_W-1:0]    rsp_free_way,
   output logic      [sala_pkg::WAY_W-1:0]    rsp_slot_way,
   output logic                               rsp_slot_valid,
   output logic      [sala_pkg::LINE_W-1:0]   rsp_slot_line,
   output logic                               rsp_evicted,
   output logic      [sala_pkg::LINE_W-1:0]   rsp_victim_line,
   output logic                               rsp_last
);
   import sala_pkg::*;

   localparam int SW    = (LINE_BITS < LINE_W) ? LINE_BITS : LINE_W;  // stored line width
   localparam int NW    = $clog2(WAYS + 1);
   localparam int ROW_W = WAYS * (SW + 1);
   localparam int LB    = WAYS * SW;

   state_type state_ff, state_in;

   logic [CFG_W-1:0]  ways_used_ff;
   logic [NW-1:0]     ways_eff;

   logic [OP_W-1:0]   op_ff;
   logic [SW-1:0]     line_ff;
   logic [SET_W-1:0]  set_ff;
   logic [WAY_W-1:0]  way_ff;
   logic [SET_W-1:0]  clr_ff;

   logic [WAYS-1:0]   match_ff, match_in;
   logic [WAYS-1:0]   free_ff, free_in;
   logic              ev_ff, ev_in;
   logic [SW-1:0]     ev_line_ff, ev_line_in;

   logic [LB-1:0]     row_lines_ff;
   logic [WAYS-1:0]   row_valid_ff;
   logic [NW-1:0]     cnt_ff;
   logic              list_last;

   logic              accept;
   logic              ram_we;
   logic [SET_W-1:0]  ram_waddr;
   logic [ROW_W-1:0]  ram_wdata;
   logic [ROW_W-1:0]  ram_rdata;
   logic [ROW_W-1:0]  merged_row;
   logic              ins_ok;

   logic              rsp_load_out, rsp_load_list;
   logic [WAY_W-1:0]  hit_way_enc, free_way_enc;

   // Effective associativity: 0 acts as 1, saturates at WAYS.
   always_comb begin
      if (ways_used_ff == '0) begin
         ways_eff = NW'(1);
      end else if ({1'b0, ways_used_ff} > (CFG_W + 1)'(WAYS)) begin
         ways_eff = NW'(WAYS);
      end else begin
         ways_eff = NW'(ways_used_ff);
      end
   end

   assign ins_ok    = int'(way_ff) < int'(ways_eff);
   assign list_last = ({1'b0, cnt_ff} + (NW + 1)'(1)) == {1'b0, ways_eff};
   assign accept    = start && !busy;

   sala_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_row_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (SET_W'(req_set_index)),
      .rdata (ram_rdata)
   );

   // Compare the whole set in parallel and pick out the insert target.
   always_comb begin
      match_in   = '0;
      free_in    = '0;
      ev_in      = 1'b0;
      ev_line_in = '0;
      merged_row = ram_rdata;
      for (int w = 0; w < WAYS; w++) begin
         if (w < int'(ways_eff)) begin
            match_in[w] = ram_rdata[LB + w] && (ram_rdata[w*SW +: SW] == line_ff);
            free_in[w]  = !ram_rdata[LB + w];
         end
         if (int'(way_ff) == w) begin
            ev_in                  = ram_rdata[LB + w] && ins_ok;
            ev_line_in             = ram_rdata[w*SW +: SW];
            merged_row[LB + w]     = 1'b1;
            merged_row[w*SW +: SW] = line_ff;
         end
      end
   end

   // Lowest matching and lowest free way.
   always_comb begin
      hit_way_enc  = '0;
      free_way_enc = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match_ff[w]) begin
            hit_way_enc = WAY_W'(w);
         end
         if (free_ff[w]) begin
            free_way_enc = WAY_W'(w);
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == SET_W'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (op_ff == OP_LOOKUP || op_ff == OP_INSERT) begin
               state_in = ST_OUT;
            end else if (op_ff == OP_LIST) begin
               state_in = ST_LIST;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            state_in = start ? ST_EVAL : ST_IDLE;
         end
         ST_LIST: begin
            if (list_last) begin
               state_in = start ? ST_EVAL : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the state machine
   always_comb begin
      busy          = 1'b1;
      ram_we        = 1'b0;
      ram_waddr     = set_ff;
      ram_wdata     = merged_row;
      rsp_load_out  = 1'b0;
      rsp_load_list = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
         end
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_EVAL: begin
            ram_we = (op_ff == OP_INSERT) && ins_ok;
         end
         ST_OUT: begin
            busy         = 1'b0;
            rsp_load_out = 1'b1;
         end
         ST_LIST: begin
            busy          = !list_last;
            rsp_load_list = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ways_used_ff <= WAYS_USED_RESET;
         clr_ff       <= '0;
         rsp_strobe   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_strobe <= rsp_load_out || rsp_load_list;
         if (csr_write_en) begin
            ways_used_ff <= csr_write_data;
         end
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + SET_W'(1);
         end
      end
   end

   // Item fields and per-item working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_op;
         line_ff <= req_line_id[SW-1:0];
         set_ff  <= SET_W'(req_set_index);
         way_ff  <= req_way;
      end
      if (state_ff == ST_EVAL) begin
         match_ff     <= match_in;
         free_ff      <= free_in;
         ev_ff        <= ev_in;
         ev_line_ff   <= ev_line_in;
         row_lines_ff <= ram_rdata[LB-1:0];
         row_valid_ff <= ram_rdata[ROW_W-1:LB];
         cnt_ff       <= '0;
      end else if (state_ff == ST_LIST) begin
         row_lines_ff <= row_lines_ff >> SW;
         row_valid_ff <= row_valid_ff >> 1;
         cnt_ff       <= cnt_ff + NW'(1);
      end
   end

   // Result registers; fields not belonging to the op read as zero.
   always_ff @(posedge clock) begin
      if (rsp_load_out) begin
         rsp_slot_way   <= '0;
         rsp_slot_valid <= 1'b0;
         rsp_slot_line  <= '0;
         rsp_last       <= 1'b1;
         if (op_ff == OP_LOOKUP) begin
            rsp_hit         <= |match_ff;
            rsp_hit_way     <= hit_way_enc;
            rsp_free_found  <= |free_ff;
            rsp_free_way    <= free_way_enc;
            rsp_evicted     <= 1'b0;
            rsp_victim_line <= '0;
         end else begin
            rsp_hit         <= 1'b0;
            rsp_hit_way     <= '0;
            rsp_free_found  <= 1'b0;
            rsp_free_way    <= '0;
            rsp_evicted     <= ev_ff;
            rsp_victim_line <= ev_ff ? LINE_W'(ev_line_ff) : '0;
         end
      end else if (rsp_load_list) begin
         rsp_hit         <= 1'b0;
         rsp_hit_way     <= '0;
         rsp_free_found  <= 1'b0;
         rsp_free_way    <= '0;
         rsp_evicted     <= 1'b0;
         rsp_victim_line <= '0;
         rsp_slot_way    <= WAY_W'(cnt_ff);
         rsp_slot_valid  <= row_valid_ff[0];
         rsp_slot_line   <= row_valid_ff[0] ? LINE_W'(row_lines_ff[SW-1:0]) : '0;
         rsp_last        <= list_last;
      end
   end

endmodule
`default_nettype wire
